FILE: rtl/bsfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_pkg
// Types and constants shared by the byte stuffing frame builder.
// ----------------------------------------------------------------------------
package bsfb_pkg;

  localparam int BYTE_W  = 8;
  localparam int CFG_A_W = 2;

  localparam logic [CFG_A_W-1:0] REG_HEADER = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_END    = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_ESCAPE = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'h7E;
  localparam logic [BYTE_W-1:0] END_RST    = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h7D;
  localparam logic [BYTE_W-1:0] STUFF_XOR  = 8'h20;
  localparam logic [BYTE_W:0]   FLETCH_MOD = 9'd255;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] header_flag;
    logic [BYTE_W-1:0] end_flag;
    logic [BYTE_W-1:0] escape_flag;
  } cfg_t;

  // one classified input item waiting for the line sequencer
  typedef struct packed {
    logic              need_hdr;
    logic              last;
    logic [BYTE_W-1:0] payload;
    logic [BYTE_W-1:0] low_sum;
    logic [BYTE_W-1:0] high_sum;
  } entry_t;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_DATA,
    PH_CKLO,
    PH_CKHI,
    PH_END
  } phase_t;

endpackage : bsfb_pkg
`default_nettype wire

FILE: rtl/bsfb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_front
// Accepts payload items, keeps the Fletcher-16 sums and the frame state,
// and hands classified entries to the queue.
// ----------------------------------------------------------------------------
module bsfb_front
  import bsfb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] payload,
  input  wire logic              final_byte,
  input  wire logic              q_full,
  output logic                   q_push,
  output entry_t                 q_entry
);

  logic [BYTE_W-1:0] low_sum_r, low_sum_nxt;
  logic [BYTE_W-1:0] high_sum_r, high_sum_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W:0]   s1_raw, s2_raw;
  logic [BYTE_W-1:0] s1, s2;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // both sums stay below 255, so one conditional subtract is a full mod
  always_comb begin
    s1_raw = {1'b0, low_sum_r} + {1'b0, payload};
    s1     = (s1_raw >= FLETCH_MOD) ? BYTE_W'(s1_raw - FLETCH_MOD) : s1_raw[BYTE_W-1:0];
    s2_raw = {1'b0, high_sum_r} + {1'b0, s1};
    s2     = (s2_raw >= FLETCH_MOD) ? BYTE_W'(s2_raw - FLETCH_MOD) : s2_raw[BYTE_W-1:0];
  end

  always_comb begin
    q_entry.need_hdr = !in_frame_r;
    q_entry.last     = final_byte;
    q_entry.payload  = payload;
    q_entry.low_sum  = s1;
    q_entry.high_sum = s2;

    low_sum_nxt  = low_sum_r;
    high_sum_nxt = high_sum_r;
    in_frame_nxt = in_frame_r;
    if (q_push) begin
      if (final_byte) begin
        low_sum_nxt  = '0;
        high_sum_nxt = '0;
        in_frame_nxt = 1'b0;
      end else begin
        low_sum_nxt  = s1;
        high_sum_nxt = s2;
        in_frame_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_sum_r  <= '0;
      high_sum_r <= '0;
      in_frame_r <= 1'b0;
    end else begin
      low_sum_r  <= low_sum_nxt;
      high_sum_r <= high_sum_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule : bsfb_front
`default_nettype wire

FILE: rtl/bsfb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_queue
// Short entry queue between the accepting front and the line sequencer.
// ----------------------------------------------------------------------------
module bsfb_queue
  import bsfb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        head_valid,
  output entry_t      head
);

  entry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (!push && do_pop) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule : bsfb_queue
`default_nettype wire

FILE: rtl/bsfb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_back
// Line sequencer: per queue entry, header (new frame), stuffed payload and,
// if last, stuffed checksum and end; one line byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module bsfb_back
  import bsfb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               head_valid,
  input  wire entry_t             head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BYTE_W-1:0]       out_byte,
  output logic                    out_last,
  output logic                    out_closed
);

  phase_t            phase_r, phase_nxt, eff;
  logic              second_r, second_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r, out_closed_r;
  logic              load, adv;
  logic [BYTE_W-1:0] val, byte_c;
  logic              special, closed_c, done_c;

  assign load = !out_valid_r || out_ready;
  assign adv  = head_valid && load;
  assign pop  = adv && done_c;

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_closed = out_closed_r;

  always_comb begin
    // no header when the frame is already open
    eff = (phase_r == PH_HDR && !head.need_hdr) ? PH_DATA : phase_r;

    case (eff)
      PH_DATA: val = head.payload;
      PH_CKLO: val = head.low_sum;
      PH_CKHI: val = head.high_sum;
      default: val = '0;
    endcase
    special = (val == cfg.header_flag) || (val == cfg.end_flag) ||
              (val == cfg.escape_flag);

    phase_nxt  = phase_r;
    second_nxt = second_r;
    byte_c     = '0;
    closed_c   = 1'b0;
    done_c     = 1'b0;

    case (eff)
      PH_HDR: begin
        byte_c    = cfg.header_flag;
        phase_nxt = PH_DATA;
      end
      PH_DATA, PH_CKLO, PH_CKHI: begin
        if (special && !second_r) begin
          byte_c     = cfg.escape_flag;
          second_nxt = 1'b1;
        end else begin
          byte_c     = second_r ? (val ^ STUFF_XOR) : val;
          second_nxt = 1'b0;
          case (eff)
            PH_DATA: begin
              if (head.last) begin
                phase_nxt = PH_CKLO;
              end else begin
                done_c = 1'b1;
              end
            end
            PH_CKLO: phase_nxt = PH_CKHI;
            default: phase_nxt = PH_END;
          endcase
        end
      end
      PH_END: begin
        byte_c   = cfg.end_flag;
        closed_c = 1'b1;
        done_c   = 1'b1;
      end
      default: begin
        phase_nxt = PH_HDR;
      end
    endcase

    if (done_c) begin
      phase_nxt = PH_HDR;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= byte_c;
      out_last_r   <= done_c;
      out_closed_r <= closed_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= head_valid;
      end
      if (adv) begin
        phase_r  <= phase_nxt;
        second_r <= second_nxt;
      end
    end
  end

endmodule : bsfb_back
`default_nettype wire

FILE: rtl/byte_stuffed_frame_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_frame_builder
// Path: an accepted item is written into the queue; its line bytes leave the output register.
// Throughput: one line byte per cycle from the sequencer while out_tready does not stall
//   it; an item yields 1 to 8 line bytes over the single output byte lane.
// Reset: synchronous, active low; clears sums, frame state, queue and output,
//   and loads the flag registers with 0x7E, 0x7E, 0x7D.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_builder
  import bsfb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [BYTE_W-1:0]  cfg_wdata,
  // payload stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] payload_byte
  input  wire logic               in_tlast,   // final_byte
  // line stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,  // [7:0] line_byte
  output logic                    out_tlast,  // run_last
  output logic                    out_tuser   // frame_closed
);

  cfg_t   cfg_r, cfg_nxt;
  logic   q_full, q_push, q_pop, q_head_valid;
  entry_t q_entry, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_HEADER: cfg_nxt.header_flag = cfg_wdata;
        REG_END:    cfg_nxt.end_flag    = cfg_wdata;
        REG_ESCAPE: cfg_nxt.escape_flag = cfg_wdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_flag <= HEADER_RST;
      cfg_r.end_flag    <= END_RST;
      cfg_r.escape_flag <= ESCAPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bsfb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .payload    (in_tdata),
    .final_byte (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  bsfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  bsfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_closed (out_tuser)
  );

endmodule : byte_stuffed_frame_builder
`default_nettype wire
